[rtl/sha256_stream_hash_assert.svh]
// assertion macros shared by the sha-256 stream hash modules
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH

`ifndef SYNTHESIS
`define SHS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sha256 assertion failed");
`define SHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 sequence assertion failed");
`else
`define SHS_ASSERT(lbl, prop)
`define SHS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/shs_pkg.sv]
// types, constants and round functions for the sha-256 stream hash
package shs_pkg;

    localparam logic [5:0] LAST_FILL = 6'd63;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic        load_word;
        logic [31:0] word;
        logic        start;
        logic        init;
    } shs_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } shs_stat_t;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

[rtl/shs_core.sv]
// sha-256 compression core: message schedule shift line and one round per cycle
`include "sha256_stream_hash_assert.svh"

module shs_core
    import shs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  shs_ctrl_t    ctrl,
    output shs_stat_t    stat,
    output logic [255:0] hash
);

    logic [31:0] w_reg [0:15];
    logic [31:0] v_reg [0:7];
    logic [31:0] h_reg [0:7];
    logic        run_reg;
    logic [6:0]  cnt_reg;

    logic        rounding;
    logic        finishing;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    assign rounding  = run_reg && !cnt_reg[6];
    assign finishing = run_reg && cnt_reg[6];

    assign w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign t1    = v_reg[7] + big_sigma1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
                 + ROUND_K[cnt_reg[5:0]] + w_reg[0];
    assign t2    = big_sigma0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);

    // schedule words enter from the packer or from the expansion
    always_ff @(posedge clk)
    begin
        if (ctrl.load_word || rounding)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= rounding ? w_new : ctrl.word;
        end
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (rounding)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            if (ctrl.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (rounding)
            begin
                cnt_reg <= cnt_reg + 7'd1;
            end
            else if (finishing)
            begin
                run_reg <= 1'b0;
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (ctrl.init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= INIT_H[i];
                end
            end
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = finishing;
    assign hash = {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                   h_reg[4], h_reg[5], h_reg[6], h_reg[7]};

    `SHS_ASSERT(a_start_idle, ctrl.start |-> !run_reg)
    `SHS_ASSERT(a_load_idle, ctrl.load_word |-> !run_reg)
    `SHS_ASSERT_NEXT(a_done_stops, stat.done, !run_reg)
    `SHS_ASSERT(a_cnt_bound, run_reg |-> (cnt_reg <= 7'd64))

endmodule

[rtl/sha256_stream_hash.sv]
// streaming sha-256: byte packer, padding sequencer and digest output
// usage:
//   input channel (in_valid / in_stall): one word per item with byte_value,
//   has_byte and end_of_message. an item with neither flag does nothing.
//   output channel (out_valid / out_stall): four digest words per message,
//   word_index 0 first, last_word set on word 3.
// timing:
//   the byte that fills a 64-byte block starts a compression (a load step,
//   64 rounds on the shared round unit, a hash update step) during which
//   in_stall is high. an end item is followed by the padding bytes up to
//   byte 56, the eight length bytes, one compression per block (one or
//   two), then the four words.
//   throughput is one byte per cycle between block compressions.
// reset: the hash returns to the initial values and the byte count to zero.
// stalls: while out_stall is high the current digest word holds and no
//   input is taken until all four words have been delivered.

`include "sha256_stream_hash_assert.svh"

module sha256_stream_hash
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_COMP  = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [2:0]   after_reg, after_next;
    logic         first_reg, first_next;
    logic [1:0]   idx_reg, idx_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [23:0]  acc_reg;

    logic         push_en;
    logic         push_count;
    logic [7:0]   push_byte;
    logic         digest_done;
    logic [5:0]   len_shift;
    shs_ctrl_t    ctrl;
    shs_stat_t    stat;
    logic [255:0] hash;

    assign len_shift = {~fill_reg[2:0], 3'b000};

    always_comb
    begin
        state_next  = state_reg;
        after_next  = after_reg;
        first_next  = first_reg;
        idx_next    = idx_reg;
        push_en     = 1'b0;
        push_count  = 1'b0;
        push_byte   = byte_value;
        digest_done = 1'b0;
        ctrl.start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    first_next = 1'b1;
                    if (has_byte)
                    begin
                        push_en    = 1'b1;
                        push_count = 1'b1;
                    end
                    if (has_byte && fill_reg == LAST_FILL)
                    begin
                        state_next = S_START;
                        after_next = end_of_message ? S_PAD : S_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_START:
            begin
                ctrl.start = 1'b1;
                state_next = S_COMP;
            end
            S_COMP:
            begin
                if (stat.done)
                begin
                    state_next = after_reg;
                end
            end
            S_PAD:
            begin
                if (first_reg || fill_reg != LEN_POS)
                begin
                    push_en    = 1'b1;
                    push_byte  = first_reg ? PAD_BYTE : ZERO_BYTE;
                    first_next = 1'b0;
                    if (fill_reg == LAST_FILL)
                    begin
                        state_next = S_START;
                        after_next = S_PAD;
                    end
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                push_en   = 1'b1;
                push_byte = 8'(bits_reg >> len_shift);
                if (fill_reg == LAST_FILL)
                begin
                    state_next = S_START;
                    after_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        digest_done = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ctrl.load_word = push_en && (fill_reg[1:0] == 2'b11);
        ctrl.word      = {acc_reg, push_byte};
        ctrl.init      = digest_done;
    end

    assign fill_next = push_en ? fill_reg + 6'd1 : fill_reg;
    assign bits_next = digest_done ? 64'd0 : (push_count ? bits_reg + 64'd8 : bits_reg);

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            acc_reg <= {acc_reg[15:0], push_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            after_reg <= S_IDLE;
            first_reg <= 1'b1;
            idx_reg   <= '0;
            fill_reg  <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            first_reg <= first_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
        end
    end

    shs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .hash  (hash)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 2'd3);
    assign digest_word = 64'(hash >> {~idx_reg, 6'd0});

    `SHS_ASSERT(a_out_core_idle, (state_reg == S_OUT) |-> !stat.busy)
    `SHS_ASSERT(a_len_fill, (state_reg == S_LEN) |-> (fill_reg >= LEN_POS))
    `SHS_ASSERT_NEXT(a_start_runs, (state_reg == S_START), stat.busy)
    `SHS_ASSERT(a_out_fill_zero, (state_reg == S_OUT) |-> (fill_reg == 6'd0))

endmodule

[bench/tb_sha256_stream_hash.sv]
// self-checking testbench for the sha-256 stream hash with its own digest predictor
`timescale 1ns / 1ps

module tb_sha256_stream_hash;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLDOFF_CYCLES = 400;

    typedef struct {
        logic [7:0]  value;
        logic        has;
        logic        eom;
        int unsigned gap;
    } stream_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  index;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_value = 8'h00;
    logic        has_byte = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    stream_item_t pending_items[$];
    digest_word_t digest_words_due[$];

    logic [7:0]  msg_block [64];
    int          msg_fill;
    logic [63:0] msg_bit_len;
    logic [31:0] chain_h [8];

    stream_item_t stage_item;
    logic         staged;
    int           gap_left;
    int           pause_left;
    int           words_seen;
    int           holdoff_left;
    logic         holdoff_used;
    int           cycle_count;
    int           mismatches;

    sha256_stream_hash dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_value     (byte_value),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 64; i++)
            msg_block[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            chain_h[i] = SHA_H0[i];
        msg_fill = 0;
        msg_bit_len = 64'd0;
    endtask

    task automatic crunch_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4 * i], msg_block[4 * i + 1],
                    msg_block[4 * i + 2], msg_block[4 * i + 3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3);
            s1 = ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10);
            w[i] = w[i - 16] + s0 + w[i - 7] + s1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain_h[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endtask

    task automatic sha_absorb(input logic [7:0] value, input logic has, input logic eom);
        digest_word_t dw;
        if (has)
        begin
            msg_block[msg_fill] = value;
            msg_fill = msg_fill + 1;
            msg_bit_len = msg_bit_len + 64'd8;
            if (msg_fill == 64)
            begin
                crunch_block();
                msg_fill = 0;
            end
        end
        if (eom)
        begin
            msg_block[msg_fill] = 8'h80;
            msg_fill = msg_fill + 1;
            if (msg_fill > 56)
            begin
                while (msg_fill < 64)
                begin
                    msg_block[msg_fill] = 8'h00;
                    msg_fill = msg_fill + 1;
                end
                crunch_block();
                msg_fill = 0;
            end
            while (msg_fill < 56)
            begin
                msg_block[msg_fill] = 8'h00;
                msg_fill = msg_fill + 1;
            end
            for (int i = 0; i < 8; i++)
                msg_block[56 + i] = msg_bit_len[63 - 8 * i -: 8];
            crunch_block();
            for (int i = 0; i < 4; i++)
            begin
                dw.value = {chain_h[2 * i], chain_h[2 * i + 1]};
                dw.index = 2'(i);
                dw.last = (i == 3);
                digest_words_due.push_back(dw);
            end
            restart_hash();
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic queue_item(input logic [7:0] value, input logic has, input logic eom,
                              input logic calm);
        stream_item_t it;
        it.value = value;
        it.has = has;
        it.eom = eom;
        it.gap = calm ? 0 : $urandom_range(0, 4);
        pending_items.push_back(it);
    endtask

    task automatic build_stimulus();
        int counted;
        int msgs;
        int len;
        logic sep_end;
        logic calm;
        // directed: empty messages, ignored bytes, extremes, short message
        queue_item(8'hff, 1'b0, 1'b0, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b1, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1, 1'b0);
        queue_item(8'h61, 1'b1, 1'b0, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b0, 1'b1);
        queue_item(8'ha5, 1'b0, 1'b0, 1'b1);
        queue_item(8'hff, 1'b1, 1'b0, 1'b1);
        queue_item(8'h3c, 1'b0, 1'b1, 1'b1);
        queue_item(8'hff, 1'b0, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b1, 1'b0);
        queue_item(8'hff, 1'b1, 1'b1, 1'b0);
        counted = 0;
        msgs = 0;
        while (counted < 260 || msgs < 4)
        begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(50, 70);
                2: len = $urandom_range(0, 130);
                default: len = $urandom_range(115, 130);
            endcase
            sep_end = (len == 0) || ($urandom_range(0, 1) == 1);
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_item(8'($urandom), 1'b0, 1'b0, calm);
                queue_item(8'($urandom), 1'b1, !sep_end && (i == len - 1), calm);
                counted = counted + 1;
            end
            if (sep_end)
            begin
                queue_item(8'($urandom), 1'b0, 1'b1, calm);
                counted = counted + 1;
            end
            msgs = msgs + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            byte_value <= 8'h00;
            has_byte <= 1'b0;
            end_of_message <= 1'b0;
            staged = 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                sha_absorb(byte_value, has_byte, end_of_message);
            if (!(in_valid && in_stall))
            begin
                if (!staged && pending_items.size() > 0)
                begin
                    stage_item = pending_items.pop_front();
                    staged = 1'b1;
                    gap_left = stage_item.gap;
                end
                if (staged && gap_left == 0)
                begin
                    in_valid <= 1'b1;
                    byte_value <= stage_item.value;
                    has_byte <= stage_item.has;
                    end_of_message <= stage_item.eom;
                    staged = 1'b0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (staged)
                        gap_left = gap_left - 1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            words_seen <= 0;
            pause_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_words_due.size() == 0)
                    flag_mismatch($sformatf("digest word %h with nothing expected",
                                            digest_word));
                else
                begin
                    digest_word_t dw;
                    dw = digest_words_due.pop_front();
                    if (digest_word !== dw.value)
                        flag_mismatch($sformatf("digest_word %h, expected %h",
                                                digest_word, dw.value));
                    if (word_index !== dw.index)
                        flag_mismatch($sformatf("word_index %0d, expected %0d",
                                                word_index, dw.index));
                    if (last_word !== dw.last)
                        flag_mismatch($sformatf("last_word %b, expected %b",
                                                last_word, dw.last));
                end
                words_seen <= words_seen + 1;
                pause_left = ((words_seen / 16) % 3 == 2) ? 0 : $urandom_range(0, 4);
            end
            else if (pause_left > 0)
                pause_left = pause_left - 1;
            out_stall <= (pause_left > 0) || (holdoff_left > 0);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_used <= 1'b0;
        end
        else if (!holdoff_used && out_valid && words_seen >= 12)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_used <= 1'b1;
        end
        else if (holdoff_left > 0)
            holdoff_left <= holdoff_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** sha256_stream_hash: FAILED **");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        mismatches = 0;
        restart_hash();
        build_stimulus();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // sample at the falling edge so the driver's updates have settled
        while (pending_items.size() > 0 || staged || in_valid)
            @(negedge clk);
        while (digest_words_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (digest_words_due.size() != 0)
            flag_mismatch($sformatf("%0d digest words never arrived", digest_words_due.size()));
        if (mismatches == 0)
            $display("** sha256_stream_hash: PASSED **");
        else
            $display("** sha256_stream_hash: FAILED **");
        $finish;
    end

endmodule
